/* rtl/cfa_pkg.sv */
// Package with the operation and status codes of the complex fixed-point ALU.
`timescale 1ns / 1ps

package cfa_pkg;

    localparam int ACT_W = 3;
    localparam int ST_W  = 2;

    localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DOT = 3'd4;

    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_SAT = 2'd1;
    localparam logic [ST_W-1:0] ST_DZ  = 2'd2;

endpackage

/* rtl/cfa_div.sv */
// Pipelined restoring divider: rounded (num << FRAC_BITS) / den, one quotient bit per stage.
`timescale 1ns / 1ps

module cfa_div #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                      i_clk,
    input  logic [2*DATA_WIDTH-1:0]   i_num,
    input  logic [2*DATA_WIDTH-1:0]   i_den,
    output logic [DATA_WIDTH+1:0]     o_quot
);

    localparam int NW = 2 * DATA_WIDTH;
    localparam int QB = DATA_WIDTH + 1;
    localparam int RW = NW + DATA_WIDTH + FRAC_BITS + 2;

    logic [RW-1:0]   r_rem [0:QB];
    logic [NW-1:0]   r_den [0:QB];
    logic [QB-1:0]   r_q   [0:QB];
    logic            r_ovr [0:QB];
    logic [QB:0]     r_quot;

    logic [RW-1:0]   w_x;
    logic            w_rnd;

    assign w_x = RW'(i_num) << FRAC_BITS;

    // Quotients that do not fit in QB bits saturate anyway, so they are only flagged.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_x;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_ovr[0] <= w_x >= (RW'(i_den) << QB);
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        localparam int K = QB - j;
        logic [RW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = RW'(r_den[j-1]) << K;
        assign w_ge = r_rem[j-1] >= w_sh;

        always_ff @(posedge i_clk) begin
            r_rem[j] <= w_ge ? (r_rem[j-1] - w_sh) : r_rem[j-1];
            r_q[j]   <= r_q[j-1] | (QB'(w_ge) << K);
            r_den[j] <= r_den[j-1];
            r_ovr[j] <= r_ovr[j-1];
        end
    end

    // Round to nearest, ties away from zero: bump when twice the remainder reaches the divisor.
    assign w_rnd = (r_rem[QB] << 1) >= RW'(r_den[QB]);

    always_ff @(posedge i_clk) begin
        if (r_ovr[QB]) begin
            r_quot <= (QB+1)'(1) << QB;
        end else begin
            r_quot <= {1'b0, r_q[QB]} + (QB+1)'(w_rnd);
        end
    end

    assign o_quot = r_quot;

endmodule

/* rtl/complex_fixed_point_alu.sv */
// Top level of the pipelined complex fixed-point ALU.
//
// Usage: drive i_action and the four operand parts and raise start; the request
// is taken at any rising edge where start is high and busy is low. busy is low
// whenever reset is not asserted, so a new request can enter every cycle.
// Each request gives exactly one result, shown for one cycle with o_valid high
// on o_res_re, o_res_im and o_status, in request order.
// Every operation has the same latency, set by the divider, which resolves one
// quotient bit per stage; the other operations ride a matching delay line so
// results never reorder.
// Throughput is one request per cycle.
// Stages: products, sums, rounding and saturation, the divider, output select.
// Reset is synchronous and clears every valid bit in flight; requests in the
// pipeline are dropped. The receiver cannot stall, so no result is ever held.
`timescale 1ns / 1ps

module complex_fixed_point_alu
    import cfa_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ACT_W-1:0]             i_action,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic [ST_W-1:0]              o_status
);

    localparam int DW      = DATA_WIDTH;
    localparam int NW      = 2 * DW;
    localparam int WW      = 2 * DW + 2;
    localparam int DLY     = DW + 3;
    localparam int LATENCY = DW + 7;

    localparam logic signed [WW-1:0] MAXV = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [WW-1:0] MINV = ~MAXV;
    localparam logic [WW-1:0] RND_POS = (FRAC_BITS == 0) ? '0 : (WW'(1) << (FRAC_BITS - 1));
    localparam logic [WW-1:0] RND_NEG = (WW'(1) << FRAC_BITS) - WW'(1) - RND_POS;
    localparam logic [DW+1:0] QMAX_POS = {3'b000, {(DW-1){1'b1}}};
    localparam logic [DW+1:0] QMAX_NEG = {2'b00, 1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic [ST_W-1:0]      status;
        logic                 is_div;
        logic                 dz;
        logic                 neg_re;
        logic                 neg_im;
    } t_side;

    // Stage 1: operands and products.
    logic                  r1_vld;
    logic [ACT_W-1:0]      r1_act;
    logic signed [DW-1:0]  r1_a_re, r1_a_im, r1_b_re, r1_b_im;
    logic signed [NW-1:0]  r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_p_bb_r, r1_p_bb_i;

    // Stage 2: sums.
    logic                  r2_vld;
    logic [ACT_W-1:0]      r2_act;
    logic signed [WW-1:0]  r2_re, r2_im;
    logic                  r2_rnd;
    logic [NW-1:0]         r2_den;
    logic signed [WW-1:0]  n2_re, n2_im;

    // Stage 3: rounding, saturation and divider operands.
    logic                  r3_vld;
    t_side                 r3_side;
    logic [NW-1:0]         r3_num_re, r3_num_im, r3_den;
    t_side                 n3_side;
    logic [DW:0]           w_sat_re, w_sat_im;
    logic signed [WW-1:0]  w_x_re, w_x_im;

    // Delay line matching the divider.
    logic                  r_dly_vld [0:DLY-1];
    t_side                 r_dly     [0:DLY-1];
    t_side                 w_tail;

    logic [DW+1:0]         w_q_re, w_q_im;

    logic                  r_vld;
    logic signed [DW-1:0]  r_res_re, r_res_im;
    logic [ST_W-1:0]       r_status;
    logic signed [DW-1:0]  n_res_re, n_res_im;
    logic [ST_W-1:0]       n_status;
    logic                  w_qsat_re, w_qsat_im;

    function automatic logic signed [WW-1:0] f_round(input logic signed [WW-1:0] w);
        logic signed [WW-1:0] v;
        v = w + (w[WW-1] ? RND_NEG : RND_POS);
        return v >>> FRAC_BITS;
    endfunction

    // Returns the saturation flag above the clamped value.
    function automatic logic [DW:0] f_sat(input logic signed [WW-1:0] x);
        logic [DW:0] r;
        if (x > MAXV) begin
            r = {1'b1, MAXV[DW-1:0]};
        end else if (x < MINV) begin
            r = {1'b1, MINV[DW-1:0]};
        end else begin
            r = {1'b0, x[DW-1:0]};
        end
        return r;
    endfunction

    assign busy = ~i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start & ~busy;
        end
        r1_act    <= i_action;
        r1_a_re   <= i_a_re;
        r1_a_im   <= i_a_im;
        r1_b_re   <= i_b_re;
        r1_b_im   <= i_b_im;
        r1_p_rr   <= i_a_re * i_b_re;
        r1_p_ii   <= i_a_im * i_b_im;
        r1_p_ri   <= i_a_re * i_b_im;
        r1_p_ir   <= i_a_im * i_b_re;
        r1_p_bb_r <= i_b_re * i_b_re;
        r1_p_bb_i <= i_b_im * i_b_im;
    end

    always_comb begin
        n2_re = '0;
        n2_im = '0;
        case (r1_act) inside
            ACT_ADD: begin
                n2_re = WW'(r1_a_re) + WW'(r1_b_re);
                n2_im = WW'(r1_a_im) + WW'(r1_b_im);
            end
            ACT_SUB: begin
                n2_re = WW'(r1_a_re) - WW'(r1_b_re);
                n2_im = WW'(r1_a_im) - WW'(r1_b_im);
            end
            ACT_MUL: begin
                n2_re = WW'(r1_p_rr) - WW'(r1_p_ii);
                n2_im = WW'(r1_p_ri) + WW'(r1_p_ir);
            end
            ACT_DIV: begin
                n2_re = WW'(r1_p_rr) + WW'(r1_p_ii);
                n2_im = WW'(r1_p_ir) - WW'(r1_p_ri);
            end
            ACT_DOT: begin
                n2_re = WW'(r1_p_rr) + WW'(r1_p_ii);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_act <= r1_act;
        r2_re  <= n2_re;
        r2_im  <= n2_im;
        r2_rnd <= (r1_act == ACT_MUL) || (r1_act == ACT_DOT);
        r2_den <= NW'(WW'(r1_p_bb_r) + WW'(r1_p_bb_i));
    end

    assign w_x_re   = r2_rnd ? f_round(r2_re) : r2_re;
    assign w_x_im   = r2_rnd ? f_round(r2_im) : r2_im;
    assign w_sat_re = f_sat(w_x_re);
    assign w_sat_im = f_sat(w_x_im);

    always_comb begin
        n3_side.re     = w_sat_re[DW-1:0];
        n3_side.im     = w_sat_im[DW-1:0];
        n3_side.status = (w_sat_re[DW] | w_sat_im[DW]) ? ST_SAT : ST_OK;
        n3_side.is_div = (r2_act == ACT_DIV);
        n3_side.dz     = (r2_den == '0);
        n3_side.neg_re = r2_re[WW-1];
        n3_side.neg_im = r2_im[WW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_side   <= n3_side;
        r3_num_re <= NW'(r2_re[WW-1] ? -r2_re : r2_re);
        r3_num_im <= NW'(r2_im[WW-1] ? -r2_im : r2_im);
        r3_den    <= r2_den;
    end

    cfa_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_re (
        .i_clk  (i_clk),
        .i_num  (r3_num_re),
        .i_den  (r3_den),
        .o_quot (w_q_re)
    );

    cfa_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_im (
        .i_clk  (i_clk),
        .i_num  (r3_num_im),
        .i_den  (r3_den),
        .o_quot (w_q_im)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_vld[0] <= 1'b0;
        end else begin
            r_dly_vld[0] <= r3_vld;
        end
        r_dly[0] <= r3_side;
    end

    for (genvar s = 1; s < DLY; s++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dly_vld[s] <= 1'b0;
            end else begin
                r_dly_vld[s] <= r_dly_vld[s-1];
            end
            r_dly[s] <= r_dly[s-1];
        end
    end

    assign w_tail = r_dly[DLY-1];

    assign w_qsat_re = w_tail.neg_re ? (w_q_re > QMAX_NEG) : (w_q_re > QMAX_POS);
    assign w_qsat_im = w_tail.neg_im ? (w_q_im > QMAX_NEG) : (w_q_im > QMAX_POS);

    always_comb begin
        n_res_re = w_tail.re;
        n_res_im = w_tail.im;
        n_status = w_tail.status;
        if (w_tail.is_div) begin
            if (w_tail.dz) begin
                n_res_re = '0;
                n_res_im = '0;
                n_status = ST_DZ;
            end else begin
                if (w_qsat_re) begin
                    n_res_re = w_tail.neg_re ? MINV[DW-1:0] : MAXV[DW-1:0];
                end else begin
                    n_res_re = w_tail.neg_re ? -w_q_re[DW-1:0] : w_q_re[DW-1:0];
                end
                if (w_qsat_im) begin
                    n_res_im = w_tail.neg_im ? MINV[DW-1:0] : MAXV[DW-1:0];
                end else begin
                    n_res_im = w_tail.neg_im ? -w_q_im[DW-1:0] : w_q_im[DW-1:0];
                end
                n_status = (w_qsat_re | w_qsat_im) ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= r_dly_vld[DLY-1];
        end
        r_res_re <= n_res_re;
        r_res_im <= n_res_im;
        r_status <= n_status;
    end

    assign o_valid  = r_vld;
    assign o_res_re = r_res_re;
    assign o_res_im = r_res_im;
    assign o_status = r_status;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("request did not produce a result at the fixed latency");

    a_dz_zero: assert property (@(posedge i_clk)
        (o_valid && (o_status == ST_DZ)) |-> ((o_res_re == '0) && (o_res_im == '0)))
        else $error("divide by zero result is not zero");

    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");
`endif

endmodule
